>>> sv/tss_pkg.sv
package tss_pkg;

  // Default size of the shared store.
  localparam int unsigned TSS_DEPTH      = 32;
  localparam int unsigned TSS_WORD_WIDTH = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_PUSHED   = 2'd0,
    STAT_MOVED    = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_READ     = 2'd3
  } status_e;

  // Request operation codes.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Stack selector codes.
  localparam logic [1:0] SEL_FIRST  = 2'd0;
  localparam logic [1:0] SEL_SECOND = 2'd1;
  localparam logic [1:0] SEL_THIRD  = 2'd2;

  // Sequencer step addresses.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_EMIT  = 3'd2,
    ST_COPY  = 3'd3,
    ST_GAP   = 3'd4,
    ST_FINAL = 3'd5
  } step_e;

  // Store operation selected by a control word.
  typedef enum logic [2:0] {
    MEM_NONE  = 3'd0,
    MEM_ITEM  = 3'd1,
    MEM_CLEAR = 3'd2,
    MEM_COPY  = 3'd3,
    MEM_GAP   = 3'd4,
    MEM_FINAL = 3'd5
  } mem_op_e;

  // How the step counter moves on.
  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_DISPATCH = 2'd1,
    SEQ_LOOP     = 2'd2,
    SEQ_EMIT     = 2'd3
  } seq_e;

  typedef struct packed {
    mem_op_e mem_op;
    seq_e    seq;
    logic    ready;
    step_e   target;
  } ctrl_t;

  // Microprogram: one control word per step.
  function automatic ctrl_t ucode(input step_e step);
    ctrl_t cw;
    case (step)
      ST_CLEAR: cw = '{mem_op: MEM_CLEAR, seq: SEQ_LOOP,     ready: 1'b0, target: ST_IDLE};
      ST_IDLE:  cw = '{mem_op: MEM_ITEM,  seq: SEQ_DISPATCH, ready: 1'b1, target: ST_EMIT};
      ST_EMIT:  cw = '{mem_op: MEM_NONE,  seq: SEQ_EMIT,     ready: 1'b0, target: ST_IDLE};
      ST_COPY:  cw = '{mem_op: MEM_COPY,  seq: SEQ_LOOP,     ready: 1'b0, target: ST_GAP};
      ST_GAP:   cw = '{mem_op: MEM_GAP,   seq: SEQ_LOOP,     ready: 1'b0, target: ST_FINAL};
      ST_FINAL: cw = '{mem_op: MEM_FINAL, seq: SEQ_NEXT,     ready: 1'b0, target: ST_EMIT};
      default:  cw = '{mem_op: MEM_NONE,  seq: SEQ_NEXT,     ready: 1'b0, target: ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> sv/tss_if.sv
// Request channel: one push or read per request.
interface tss_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  stack_select;
  logic [31:0] push_value;
  logic [4:0]  read_index;

  modport source (output valid, operation, stack_select, push_value, read_index,
                  input ready);
  modport sink   (input valid, operation, stack_select, push_value, read_index,
                  output ready);
endinterface

// Result channel: one result per request.
interface tss_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic [5:0]  first_top;
  logic [5:0]  second_base;
  logic [5:0]  second_top;
  logic [4:0]  third_top;

  modport source (output valid, status, read_data, first_top, second_base, second_top,
                  third_top, input ready);
  modport sink   (input valid, status, read_data, first_top, second_base, second_top,
                  third_top, output ready);
endinterface

>>> sv/tss_ram.sv
// Single-port-write, single-port-read store with registered read data.
module tss_ram #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned WORD_WIDTH = 32,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         wa_i,
  input  logic [WORD_WIDTH-1:0] wd_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         ra_i,
  output logic [WORD_WIDTH-1:0] rd_o
);

  logic [WORD_WIDTH-1:0] mem_q [DEPTH];
  logic [WORD_WIDTH-1:0] rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem_q[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

>>> sv/three_stacks_shared_array.sv
// Three stacks in one shared word store.
// Requests arrive on req_i (valid/ready): a push of push_value onto the stack
// chosen by stack_select, or a read of store slot read_index. Each request
// gives exactly one result on rsp_o (valid/ready) with a status, the read word
// (zero for pushes) and the stack pointers after the request.
// For a read or an ordinary push, the store access happens at the accepting
// edge; the sequencer then goes to its emit step, which loads the result
// register once that register is free. The sequencer is back in its idle step
// right after that load, and takes no new request before that load.
// A push to stack two that runs into stack three moves stack two down: the
// sequencer copies stack two, clears the slots left behind and then pushes,
// working through the single write port of the store, one slot per cycle.
// After reset the sequencer clears the store one slot per cycle, all DEPTH
// slots; req_i.ready stays low during that pass.
// The result register frees the request side: a new request is accepted while
// a result still waits, and only the next result waits for rsp_o.ready.
module three_stacks_shared_array
  import tss_pkg::*;
#(
  parameter int unsigned DEPTH      = TSS_DEPTH,
  parameter int unsigned WORD_WIDTH = TSS_WORD_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tss_req_if.sink   req_i,
  tss_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned XW = PW + 2;

  // Sequencer state.
  step_e   step_q, step_d;
  ctrl_t   ctrl;
  logic [PW-1:0] cnt_q, cnt_d;
  logic    loop_done;
  logic    accept;
  logic    out_free;
  logic    reloc;

  // Stack pointers.
  logic [PW-1:0] first_q, first_d;
  logic [PW-1:0] base_q, base_d;
  logic [PW-1:0] second_q, second_d;
  logic [PW-1:0] third_q, third_d;

  // Latched request context.
  status_e               status_q, status_d;
  logic                  hit_q, hit_d;
  logic [WORD_WIDTH-1:0] val_q;
  logic [PW-1:0]         nbase_q, ntop_q, size_q;

  // Result register.
  logic        ovalid_q;
  status_e     ostatus_q;
  logic [31:0] odata_q;
  logic [5:0]  ofirst_q, obase_q, osecond_q;
  logic [4:0]  othird_q;

  // Store port signals.
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa, mem_ra;
  logic [WORD_WIDTH-1:0] mem_wd, mem_rd;

  // Request decode.
  logic [WORD_WIDTH+31:0] val_ext;
  logic [WORD_WIDTH-1:0]  val_w;
  logic [AW+4:0]          idx_ext;
  logic                   idx_hit;
  logic [XW-1:0]          size_x, nbase_x, ntop_x, plus2_x;
  logic                   p1_ok, p2_fit, p3_ok, reloc_ok;
  logic [PW-1:0]          gap_addr, copy_ra, copy_wa, ntop_inc;

  assign ctrl     = ucode(step_q);
  assign accept   = ctrl.ready && req_i.valid;
  assign out_free = !ovalid_q || rsp_o.ready;
  assign req_i.ready = ctrl.ready;

  // Push value kept in a store word, read index mapped to a slot.
  assign val_ext = {{WORD_WIDTH{req_i.push_value[31]}}, req_i.push_value};
  assign val_w   = val_ext[WORD_WIDTH-1:0];
  assign idx_ext = {{AW{1'b0}}, req_i.read_index};
  assign idx_hit = 32'(req_i.read_index) < DEPTH;

  // Push checks and relocation geometry.
  assign p1_ok    = first_q < base_q;
  assign p2_fit   = second_q < third_q;
  assign p3_ok    = (third_q >= second_q) && (third_q != '0);
  assign size_x   = XW'(second_q) - XW'(base_q);
  assign nbase_x  = XW'(first_q) + XW'(3);
  assign plus2_x  = XW'(first_q) + XW'(2);
  assign ntop_x   = nbase_x + size_x;
  assign reloc_ok = (plus2_x < XW'(base_q)) && (ntop_x <= XW'(third_q));
  assign reloc    = (req_i.operation == OP_PUSH) && (req_i.stack_select == SEL_SECOND)
                    && !p2_fit && reloc_ok;

  // Loop addresses.
  assign gap_addr = ntop_q + cnt_q;
  assign copy_ra  = base_q + cnt_q;
  assign copy_wa  = nbase_q + cnt_q - PW'(1);
  assign ntop_inc = ntop_q + PW'(1);

  // Loop end test for the current step.
  always_comb begin
    case (ctrl.mem_op)
      MEM_CLEAR: loop_done = (cnt_q == PW'(DEPTH - 1));
      MEM_COPY:  loop_done = (cnt_q == size_q);
      MEM_GAP:   loop_done = (gap_addr == third_q);
      default:   loop_done = 1'b1;
    endcase
  end

  // Next step and step counter.
  always_comb begin
    step_d = step_q;
    cnt_d  = '0;
    case (ctrl.seq)
      SEQ_DISPATCH: begin
        if (accept) begin
          step_d = reloc ? ST_COPY : ctrl.target;
        end
      end
      SEQ_LOOP: begin
        if (loop_done) begin
          step_d = ctrl.target;
        end else begin
          cnt_d = cnt_q + PW'(1);
        end
      end
      SEQ_EMIT: begin
        if (out_free) begin
          step_d = ctrl.target;
        end
      end
      default: step_d = ctrl.target;
    endcase
  end

  // Datapath controls from the control word.
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    mem_re   = 1'b0;
    mem_ra   = copy_ra[AW-1:0];
    first_d  = first_q;
    base_d   = base_q;
    second_d = second_q;
    third_d  = third_q;
    status_d = status_q;
    hit_d    = hit_q;
    case (ctrl.mem_op)
      MEM_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[AW-1:0];
      end
      MEM_ITEM: begin
        if (accept) begin
          hit_d    = 1'b0;
          status_d = STAT_OVERFLOW;
          if (req_i.operation == OP_READ) begin
            status_d = STAT_READ;
            hit_d    = idx_hit;
            mem_re   = 1'b1;
            mem_ra   = idx_ext[AW-1:0];
          end else begin
            case (req_i.stack_select)
              SEL_FIRST: begin
                if (p1_ok) begin
                  mem_we   = 1'b1;
                  mem_wa   = first_q[AW-1:0];
                  mem_wd   = val_w;
                  first_d  = first_q + PW'(1);
                  status_d = STAT_PUSHED;
                end
              end
              SEL_SECOND: begin
                if (p2_fit) begin
                  mem_we   = 1'b1;
                  mem_wa   = second_q[AW-1:0];
                  mem_wd   = val_w;
                  second_d = second_q + PW'(1);
                  status_d = STAT_PUSHED;
                end else if (reloc_ok) begin
                  status_d = STAT_MOVED;
                end
              end
              SEL_THIRD: begin
                if (p3_ok) begin
                  mem_we   = 1'b1;
                  mem_wa   = third_q[AW-1:0];
                  mem_wd   = val_w;
                  third_d  = third_q - PW'(1);
                  status_d = STAT_PUSHED;
                end
              end
              default: status_d = STAT_OVERFLOW;
            endcase
          end
        end
      end
      MEM_COPY: begin
        mem_re = 1'b1;
        mem_we = (cnt_q != '0);
        mem_wa = copy_wa[AW-1:0];
        mem_wd = mem_rd;
      end
      MEM_GAP: begin
        mem_we = 1'b1;
        mem_wa = gap_addr[AW-1:0];
      end
      MEM_FINAL: begin
        mem_we   = 1'b1;
        mem_wa   = ntop_q[AW-1:0];
        mem_wd   = val_q;
        base_d   = nbase_q;
        second_d = ntop_inc;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Control and pointer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= ST_CLEAR;
      cnt_q    <= '0;
      first_q  <= '0;
      base_q   <= PW'(DEPTH / 2);
      second_q <= PW'(DEPTH / 2);
      third_q  <= PW'(DEPTH - 1);
      status_q <= STAT_OVERFLOW;
      hit_q    <= 1'b0;
    end else begin
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      first_q  <= first_d;
      base_q   <= base_d;
      second_q <= second_d;
      third_q  <= third_d;
      status_q <= status_d;
      hit_q    <= hit_d;
    end
  end

  // Relocation context, captured with the request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q   <= val_w;
      nbase_q <= nbase_x[PW-1:0];
      ntop_q  <= ntop_x[PW-1:0];
      size_q  <= size_x[PW-1:0];
    end
  end

  // Result register.
  logic        load_out;
  logic [WORD_WIDTH+31:0] rd_ext;
  logic [PW+5:0] first_ext, base_ext, second_ext, third_ext;

  assign load_out   = (ctrl.seq == SEQ_EMIT) && out_free;
  assign rd_ext     = {{32{mem_rd[WORD_WIDTH-1]}}, mem_rd};
  assign first_ext  = {6'b0, first_q};
  assign base_ext   = {6'b0, base_q};
  assign second_ext = {6'b0, second_q};
  assign third_ext  = {6'b0, third_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ostatus_q <= status_q;
      odata_q   <= hit_q ? rd_ext[31:0] : 32'd0;
      ofirst_q  <= first_ext[5:0];
      obase_q   <= base_ext[5:0];
      osecond_q <= second_ext[5:0];
      othird_q  <= third_ext[4:0];
    end
  end

  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.status      = ostatus_q;
  assign rsp_o.read_data   = odata_q;
  assign rsp_o.first_top   = ofirst_q;
  assign rsp_o.second_base = obase_q;
  assign rsp_o.second_top  = osecond_q;
  assign rsp_o.third_top   = othird_q;

  // Shared word store.
  tss_ram #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk_i (clk_i),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .re_i  (mem_re),
    .ra_i  (mem_ra),
    .rd_o  (mem_rd)
  );

`ifndef ASSERT_OFF
  // Stack one never passes the base of stack two.
  assert property (@(posedge clk_i) disable iff (!rst_ni) first_q <= base_q)
    else $error("stack one crossed the base of stack two");

  // Stack two never has a negative size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) base_q <= second_q)
    else $error("stack two top below its base");

  // A relocation always starts from an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_COPY) && ($past(step_q) != ST_COPY) |-> $past(accept))
    else $error("relocation started without a request");

  // Gap clearing never reaches past the top of stack three.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_GAP) |-> (gap_addr <= third_q))
    else $error("gap clear beyond stack three");
`endif

endmodule

>>> dv/tss_result_checker.sv
// Watches both channels of the three-stack store, keeps its own copy of the
// store and the stack pointers, and checks every result against it in order.
module tss_result_checker
  import tss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tss_req_if   req_i,
  tss_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   outstanding_o,
  output int   relocations_o,
  output int   overflows_o
);

  // One predicted result.
  typedef struct packed {
    status_e     status;
    logic [31:0] read_data;
    logic [5:0]  first_top;
    logic [5:0]  second_base;
    logic [5:0]  second_top;
    logic [4:0]  third_top;
  } stack_result_t;

  // Shadow copy of the store and the stack pointers.
  logic [31:0] word_model [TSS_DEPTH];
  int unsigned first_free;
  int unsigned base_two;
  int unsigned top_two;
  int unsigned third_free;

  stack_result_t pending_results [$];
  int            fails;
  int            moves;
  int            overflows;

  // Applies one request to the shadow state and returns the result it gives.
  function automatic stack_result_t apply_request(input op_e op, input logic [1:0] sel,
                                                   input logic [31:0] val,
                                                   input logic [4:0] idx);
    stack_result_t r;
    int unsigned   span;
    int unsigned   new_base;
    int unsigned   new_top;
    int unsigned   k;
    r.status    = STAT_OVERFLOW;
    r.read_data = '0;
    if (op == OP_READ) begin
      r.status = STAT_READ;
      if (idx < TSS_DEPTH) begin
        r.read_data = word_model[idx];
      end
    end else begin
      case (sel)
        SEL_FIRST: begin
          if (first_free < base_two) begin
            word_model[first_free] = val;
            first_free++;
            r.status = STAT_PUSHED;
          end
        end
        SEL_SECOND: begin
          if (top_two < third_free) begin
            word_model[top_two] = val;
            top_two++;
            r.status = STAT_PUSHED;
          end else begin
            // Stack two is blocked: slide it down to three slots above stack one,
            // clear what it leaves behind up to stack three, then push.
            span     = top_two - base_two;
            new_base = first_free + 3;
            new_top  = new_base + span;
            if (first_free + 2 < base_two && new_top <= third_free) begin
              for (k = 0; k < span; k++) begin
                word_model[new_base + k] = word_model[base_two + k];
              end
              for (k = new_top; k <= third_free && k < TSS_DEPTH; k++) begin
                word_model[k] = '0;
              end
              base_two            = new_base;
              word_model[new_top] = val;
              top_two             = new_top + 1;
              r.status            = STAT_MOVED;
            end
          end
        end
        SEL_THIRD: begin
          if (third_free >= top_two && third_free > 0) begin
            word_model[third_free] = val;
            third_free--;
            r.status = STAT_PUSHED;
          end
        end
        default: begin
        end
      endcase
    end
    if (r.status == STAT_MOVED) moves++;
    if (r.status == STAT_OVERFLOW) overflows++;
    r.first_top   = first_free[5:0];
    r.second_base = base_two[5:0];
    r.second_top  = top_two[5:0];
    r.third_top   = third_free[4:0];
    return r;
  endfunction

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    stack_result_t want;
    int unsigned   k;
    if (!rst_ni) begin
      for (k = 0; k < TSS_DEPTH; k++) begin
        word_model[k] = '0;
      end
      first_free  = 0;
      base_two    = TSS_DEPTH / 2;
      top_two     = TSS_DEPTH / 2;
      third_free  = TSS_DEPTH - 1;
      pending_results.delete();
      fails       = 0;
      moves       = 0;
      overflows   = 0;
    end else begin
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        pending_results.push_back(apply_request(op_e'(req_i.operation), req_i.stack_select,
                                                req_i.push_value, req_i.read_index));
      end
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("Result with no request waiting: status %0d", rsp_i.status);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp_i.status);
            fails++;
          end
          if (rsp_i.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %h, got %h", want.read_data,
                   rsp_i.read_data);
            fails++;
          end
          if (rsp_i.first_top !== want.first_top) begin
            $error("first_top mismatch: expected %0d, got %0d", want.first_top,
                   rsp_i.first_top);
            fails++;
          end
          if (rsp_i.second_base !== want.second_base) begin
            $error("second_base mismatch: expected %0d, got %0d", want.second_base,
                   rsp_i.second_base);
            fails++;
          end
          if (rsp_i.second_top !== want.second_top) begin
            $error("second_top mismatch: expected %0d, got %0d", want.second_top,
                   rsp_i.second_top);
            fails++;
          end
          if (rsp_i.third_top !== want.third_top) begin
            $error("third_top mismatch: expected %0d, got %0d", want.third_top,
                   rsp_i.third_top);
            fails++;
          end
        end
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= pending_results.size();
    relocations_o <= moves;
    overflows_o   <= overflows;
  end

endmodule

>>> dv/tb.sv
// Drives pushes and reads into the three-stack store with random gaps on both
// sides; the result checker beside the block does all prediction.
module tb
  import tss_pkg::*;
();

  localparam logic [1:0]  SEL_UNUSED     = 2'd3;
  localparam int unsigned TOTAL_REQUESTS = 1900;
  localparam int unsigned PAUSE_AT       = 950;
  localparam int unsigned HOLD_AT        = 400;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned CYCLE_LIMIT    = 800000;

  typedef struct packed {
    op_e         op;
    logic [1:0]  sel;
    logic [31:0] val;
    logic [4:0]  idx;
  } stack_req_t;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          outstanding;
  int          relocations;
  int          overflows;
  int unsigned sent_count;
  int unsigned read_count;
  int unsigned cycle_count;
  int unsigned no_gap_left;
  stack_req_t  directed_q [$];

  tss_req_if req ();
  tss_rsp_if rsp ();

  three_stacks_shared_array dut (
    .clk_i,
    .rst_ni,
    .req_i (req),
    .rsp_o (rsp)
  );

  tss_result_checker result_chk (
    .clk_i,
    .rst_ni,
    .req_i         (req),
    .rsp_i         (rsp),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .relocations_o (relocations),
    .overflows_o   (overflows)
  );

  // Clock and a single reset at the start.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Give up if the run hangs.
  initial begin : watchdog_proc
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random ready, plus one long hold-off while requests keep coming.
  initial begin : rsp_ready_proc
    int unsigned pick;
    int unsigned run_len;
    int unsigned held;
    bit          hold_done;
    rsp.ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk_i);
          held++;
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        rsp.ready <= 1'b1;
        run_len = $urandom_range(1, 60);
      end else if (pick < 95) begin
        rsp.ready <= 1'b0;
        run_len = $urandom_range(1, 3);
      end else begin
        rsp.ready <= 1'b0;
        run_len = $urandom_range(10, 40);
      end
      repeat (run_len) @(posedge clk_i);
    end
  end

  function automatic stack_req_t make_request(input op_e op, input logic [1:0] sel,
                                              input logic [31:0] val,
                                              input logic [4:0] idx);
    stack_req_t r;
    r.op  = op;
    r.sel = sel;
    r.val = val;
    r.idx = idx;
    return r;
  endfunction

  // Mostly pushes spread over the three stacks, some reads and a few bad selects.
  function automatic stack_req_t random_request();
    stack_req_t  r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.op = (pick < 35) ? OP_READ : OP_PUSH;
    pick = $urandom_range(0, 99);
    if (pick < 5) r.sel = SEL_UNUSED;
    else if (pick < 40) r.sel = SEL_FIRST;
    else if (pick < 75) r.sel = SEL_SECOND;
    else r.sel = SEL_THIRD;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       r.val = 32'h0000_0000;
        1:       r.val = 32'hFFFF_FFFF;
        2:       r.val = 32'h8000_0000;
        default: r.val = 32'h7FFF_FFFF;
      endcase
    end else begin
      r.val = $urandom();
    end
    r.idx = 5'($urandom_range(0, TSS_DEPTH - 1));
    return r;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input stack_req_t item);
    req.valid        <= 1'b1;
    req.operation    <= item.op;
    req.stack_select <= item.sel;
    req.push_value   <= item.val;
    req.read_index   <= item.idx;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    sent_count++;
    if (item.op == OP_READ) read_count++;
  endtask

  // Random gap after a request; now and then a burst with no gaps at all.
  task automatic idle_sender();
    int unsigned pick;
    int unsigned gap;
    gap = 0;
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) no_gap_left = $urandom_range(30, 80);
      else if (pick < 25) gap = $urandom_range(1, 3);
      else if (pick < 28) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Request side: directed opening, then random traffic.
  initial begin : stimulus_proc
    stack_req_t  item;
    int unsigned n;
    req.valid        <= 1'b0;
    req.operation    <= OP_PUSH;
    req.stack_select <= SEL_FIRST;
    req.push_value   <= '0;
    req.read_index   <= '0;
    sent_count  = 0;
    read_count  = 0;
    no_gap_left = 0;

    // Reads of a cleared store, extreme words on stacks one and three, a bad
    // select, then stack two filled until it must slide down below stack three.
    directed_q.push_back(make_request(OP_READ, SEL_FIRST, '0, 5'd0));
    directed_q.push_back(make_request(OP_READ, SEL_FIRST, '0, 5'd31));
    directed_q.push_back(make_request(OP_PUSH, SEL_FIRST, 32'h7FFF_FFFF, 5'd0));
    directed_q.push_back(make_request(OP_PUSH, SEL_FIRST, 32'h8000_0000, 5'd31));
    directed_q.push_back(make_request(OP_PUSH, SEL_THIRD, 32'hFFFF_FFFF, 5'd0));
    directed_q.push_back(make_request(OP_PUSH, SEL_THIRD, 32'h0000_0000, 5'd31));
    directed_q.push_back(make_request(OP_PUSH, SEL_UNUSED, 32'h1234_5678, 5'd0));
    for (n = 0; n < 14; n++) begin
      directed_q.push_back(make_request(OP_PUSH, SEL_SECOND, $urandom(), 5'd0));
    end
    directed_q.push_back(make_request(OP_READ, SEL_FIRST, '0, 5'd5));
    directed_q.push_back(make_request(OP_READ, SEL_FIRST, '0, 5'd18));
    directed_q.push_back(make_request(OP_READ, SEL_FIRST, '0, 5'd30));
    directed_q.push_back(make_request(OP_READ, SEL_FIRST, '0, 5'd31));

    @(posedge rst_ni);
    @(posedge clk_i);
    for (n = 0; n < TOTAL_REQUESTS; n++) begin
      item = (n < directed_q.size()) ? directed_q[n] : random_request();
      send_request(item);
      if (n == PAUSE_AT) wait_for_results();
      else idle_sender();
    end
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests, %0d of them reads, in %0d cycles.", sent_count,
             read_count, cycle_count);
    $display("Stack two was moved %0d times; %0d pushes overflowed.", relocations,
             overflows);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
